// ===== rtl/avt_pkg.sv =====
package avt_pkg;

   // Register indexes of the matrix configuration
   localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

   localparam int NUM_REGS  = 8;
   localparam int REG_BITS  = 64;
   localparam int IDX_BITS  = 4;
   localparam int COORD_BITS = 32;
   localparam int NUM_LANES = 4;

   // Per-lane sum width: three 64-bit floored products plus translation
   localparam int SUM_BITS  = 66;

   typedef logic [REG_BITS-1:0] reg_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_in;
      logic signed [COORD_BITS-1:0] y_in;
      logic signed [COORD_BITS-1:0] z_in;
      logic                         last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_out;
      logic signed [COORD_BITS-1:0] y_out;
      logic signed [COORD_BITS-1:0] z_out;
      logic                         rescaled;
      logic                         div_zero;
      logic                         saturated;
      logic                         last_out;
   } rsp_payload_type;

   // Flags that travel with a vertex through the divide pipeline
   typedef struct packed {
      logic last;
      logic w_one;
      logic w_zero;
   } vtx_ctl_type;

endpackage

// ===== rtl/avt_if.sv =====
interface avt_req_if;
   import avt_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface avt_rsp_if;
   import avt_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface avt_csr_if;
   import avt_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_BITS-1:0] index;
   reg_word_type        wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/affine_vertex_transform.sv =====
// Throughput: one vertex per cycle while not stalled; four row lanes and a
// fully pipelined divider (one quotient bit per stage, one divider per coordinate).
// The whole pipeline advances together and stalls only while the output
// stage holds a response that is not taken.
// Reset (synchronous, active high) clears valid bits and restores the matrix
// to identity.
module affine_vertex_transform #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   avt_req_if.sink     req,
   avt_rsp_if.source   rsp,
   avt_csr_if.sink     csr
);
   import avt_pkg::*;

   localparam int DIV_STAGES = WORD_BITS + 2;
   localparam int DEPTH = 2 + 1 + DIV_STAGES + 1;
   localparam logic [REG_BITS-1:0] ONE_LO = REG_BITS'(1) << FRAC_BITS;
   localparam logic [REG_BITS-1:0] ONE_HI = REG_BITS'(1) << (FRAC_BITS + 32);

   reg_word_type regs_ff [NUM_REGS];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic             enable;

   // Pipeline advances whenever the output slot is free or being taken
   assign enable    = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = enable;
   assign csr.ready = 1'b1;
   assign vld_in    = {vld_ff[DEPTH-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   // Matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_ROW0_COLS01] <= ONE_LO;
         regs_ff[REG_ROW0_COLS23] <= '0;
         regs_ff[REG_ROW1_COLS01] <= ONE_HI;
         regs_ff[REG_ROW1_COLS23] <= '0;
         regs_ff[REG_ROW2_COLS01] <= '0;
         regs_ff[REG_ROW2_COLS23] <= ONE_LO;
         regs_ff[REG_ROW3_COLS01] <= '0;
         regs_ff[REG_ROW3_COLS23] <= ONE_HI;
      end else if (csr.valid && csr.index < IDX_BITS'(NUM_REGS)) begin
         regs_ff[csr.index[2:0]] <= csr.wdata;
      end
   end

   // Row lanes
   logic signed [SUM_BITS-1:0] sum [NUM_LANES];
   for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
      avt_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_lane (
         .clock  (clock),
         .enable (enable),
         .cols01 (regs_ff[2*r]),
         .cols23 (regs_ff[2*r+1]),
         .vx     (req.data.x_in[WORD_BITS-1:0]),
         .vy     (req.data.y_in[WORD_BITS-1:0]),
         .vz     (req.data.z_in[WORD_BITS-1:0]),
         .sum_ff (sum[r])
      );
   end

   // last flag runs alongside the lanes
   logic last_d1_ff, last_d2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         last_d1_ff <= req.data.last_in;
         last_d2_ff <= last_d1_ff;
      end
   end

   // Classify stage: magnitudes, w tests, range checks
   localparam logic signed [SUM_BITS-1:0] MAXS = SUM_BITS'((64'(1) << (WORD_BITS-1)) - 1);
   localparam logic signed [SUM_BITS-1:0] MINS = -MAXS - 1;
   localparam logic signed [SUM_BITS-1:0] ONES = SUM_BITS'(64'(1) << FRAC_BITS);

   logic [SUM_BITS-1:0]  nmag_ff [3];
   logic [SUM_BITS-1:0]  wmag_ff;
   vtx_ctl_type          ctl_ff;
   logic                 wneg_ff;
   logic [2:0]           nneg_ff, nzero_ff, nbig_ff, nsmall_ff;
   logic [3*WORD_BITS-1:0] nword_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            nmag_ff[i]   <= sum[i][SUM_BITS-1] ? SUM_BITS'(-sum[i]) : sum[i];
            nneg_ff[i]   <= sum[i][SUM_BITS-1];
            nzero_ff[i]  <= sum[i] == '0;
            nbig_ff[i]   <= sum[i] > MAXS;
            nsmall_ff[i] <= sum[i] < MINS;
            nword_ff[i*WORD_BITS +: WORD_BITS] <= sum[i][WORD_BITS-1:0];
         end
         wmag_ff       <= sum[3][SUM_BITS-1] ? SUM_BITS'(-sum[3]) : sum[3];
         wneg_ff       <= sum[3][SUM_BITS-1];
         ctl_ff.last   <= last_d2_ff;
         ctl_ff.w_one  <= sum[3] == ONES;
         ctl_ff.w_zero <= sum[3] == '0;
      end
   end

   // Divider lanes, one per coordinate
   logic [3*(WORD_BITS+1)-1:0] quo;
   logic [2:0]                 ovf;
   for (genvar i = 0; i < 3; i++) begin : g_div
      avt_divider #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
         .clock   (clock),
         .enable  (enable),
         .num_mag (nmag_ff[i]),
         .den_mag (wmag_ff == '0 ? SUM_BITS'(1) : wmag_ff),
         .quo_ff  (quo[i*(WORD_BITS+1) +: WORD_BITS+1]),
         .ovf_ff  (ovf[i])
      );
   end

   // Side data delayed to match the divider
   vtx_ctl_type          ctl_d_ff   [DIV_STAGES];
   logic                 wneg_d_ff  [DIV_STAGES];
   logic [2:0]           nneg_d_ff  [DIV_STAGES];
   logic [2:0]           nzero_d_ff [DIV_STAGES];
   logic [2:0]           nbig_d_ff  [DIV_STAGES];
   logic [2:0]           nsml_d_ff  [DIV_STAGES];
   logic [3*WORD_BITS-1:0] nword_d_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_d_ff[0]   <= ctl_ff;
         wneg_d_ff[0]  <= wneg_ff;
         nneg_d_ff[0]  <= nneg_ff;
         nzero_d_ff[0] <= nzero_ff;
         nbig_d_ff[0]  <= nbig_ff;
         nsml_d_ff[0]  <= nsmall_ff;
         nword_d_ff[0] <= nword_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            ctl_d_ff[s]   <= ctl_d_ff[s-1];
            wneg_d_ff[s]  <= wneg_d_ff[s-1];
            nneg_d_ff[s]  <= nneg_d_ff[s-1];
            nzero_d_ff[s] <= nzero_d_ff[s-1];
            nbig_d_ff[s]  <= nbig_d_ff[s-1];
            nsml_d_ff[s]  <= nsml_d_ff[s-1];
            nword_d_ff[s] <= nword_d_ff[s-1];
         end
      end
   end

   // Output merge
   rsp_payload_type rsp_data;
   avt_merge #(.WORD_BITS(WORD_BITS)) u_merge (
      .clock     (clock),
      .enable    (enable),
      .ctl       (ctl_d_ff[DIV_STAGES-1]),
      .num_neg   (nneg_d_ff[DIV_STAGES-1]),
      .num_zero  (nzero_d_ff[DIV_STAGES-1]),
      .num_big   (nbig_d_ff[DIV_STAGES-1]),
      .num_small (nsml_d_ff[DIV_STAGES-1]),
      .num_word  (nword_d_ff[DIV_STAGES-1]),
      .w_neg     (wneg_d_ff[DIV_STAGES-1]),
      .quo       (quo),
      .ovf       (ovf),
      .rsp_ff    (rsp_data)
   );

   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.data  = rsp_data;

endmodule

// ===== rtl/avt_lane.sv =====
// One matrix row: three products floored to the fraction, plus translation.
// Two stages: products, then sum.
module avt_lane #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [avt_pkg::REG_BITS-1:0]        cols01,
   input  logic [avt_pkg::REG_BITS-1:0]        cols23,
   input  logic signed [WORD_BITS-1:0]         vx,
   input  logic signed [WORD_BITS-1:0]         vy,
   input  logic signed [WORD_BITS-1:0]         vz,
   output logic signed [avt_pkg::SUM_BITS-1:0] sum_ff
);
   import avt_pkg::*;

   localparam int PROD_BITS = 2 * WORD_BITS;

   logic signed [WORD_BITS-1:0] c0, c1, c2, c3;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [WORD_BITS-1:0] t_ff;
   logic signed [SUM_BITS-1:0]  sum_in;

   assign c0 = cols01[WORD_BITS-1:0];
   assign c1 = cols01[32 +: WORD_BITS];
   assign c2 = cols23[WORD_BITS-1:0];
   assign c3 = cols23[32 +: WORD_BITS];

   // Products, arithmetic shift floors toward minus infinity
   always_comb begin
      sum_in = SUM_BITS'(t_ff)
             + SUM_BITS'(p0_ff >>> FRAC_BITS)
             + SUM_BITS'(p1_ff >>> FRAC_BITS)
             + SUM_BITS'(p2_ff >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff  <= c0 * vx;
         p1_ff  <= c1 * vy;
         p2_ff  <= c2 * vz;
         t_ff   <= c3;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== rtl/avt_divider.sv =====
// Pipelined restoring divider: |n| << FRAC_BITS over |w|, one quotient bit
// per stage. Quotient bits beyond the saturation limit collapse into a
// sticky overflow flag, so only QBITS stages are needed.
module avt_divider #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [avt_pkg::SUM_BITS-1:0]        num_mag,
   input  logic [avt_pkg::SUM_BITS-1:0]        den_mag,
   output logic [WORD_BITS:0]                  quo_ff,
   output logic                                ovf_ff
);
   import avt_pkg::*;

   // Quotient window of WORD_BITS+1 bits holds values past lim = 2^(WORD_BITS-1); larger ones set overflow
   localparam int QBITS = WORD_BITS + 1;
   localparam int DBITS = SUM_BITS + FRAC_BITS;
   localparam int RBITS = SUM_BITS + 1;

   // Stage 0: overflow if (num << F) >= den << QBITS
   logic [DBITS-1:0]  dvd_ff [QBITS+1];
   logic [SUM_BITS-1:0] den_ff [QBITS+1];
   logic [RBITS-1:0]  rem_ff [QBITS+1];
   logic [QBITS-1:0]  q_ff   [QBITS+1];
   logic              ov_ff  [QBITS+1];

   logic [DBITS-1:0]  dvd_full;
   logic [DBITS-1:0]  hi_part;

   assign dvd_full = {num_mag, {FRAC_BITS{1'b0}}};
   assign hi_part  = dvd_full >> QBITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff[0] <= dvd_full;
         den_ff[0] <= den_mag;
         // remainder seed is the part above the quotient window
         ov_ff[0]  <= hi_part >= DBITS'(den_mag);
         rem_ff[0] <= RBITS'(hi_part);
         q_ff[0]   <= '0;
      end
   end

   for (genvar s = 0; s < QBITS; s++) begin : g_stage
      logic [RBITS-1:0] trial;
      logic [RBITS:0]   diff;
      always_comb begin
         trial = {rem_ff[s][RBITS-2:0], dvd_ff[s][QBITS-1-s]};
         diff  = {1'b0, trial} - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dvd_ff[s+1] <= dvd_ff[s];
            den_ff[s+1] <= den_ff[s];
            ov_ff[s+1]  <= ov_ff[s];
            if (!diff[RBITS] && !ov_ff[s]) begin
               rem_ff[s+1] <= diff[RBITS-1:0];
               q_ff[s+1]   <= {q_ff[s][QBITS-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= ov_ff[s] ? rem_ff[s] : trial;
               q_ff[s+1]   <= {q_ff[s][QBITS-2:0], 1'b0};
            end
         end
      end
   end

   assign quo_ff = q_ff[QBITS];
   assign ovf_ff = ov_ff[QBITS];

endmodule

// ===== rtl/avt_merge.sv =====
// Merge stage: picks pass-through, zero-w or divided result for each
// coordinate, applies sign and saturation, and gathers the flags.
module avt_merge #(
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               enable,
   input  avt_pkg::vtx_ctl_type                ctl,
   input  logic [2:0]                          num_neg,
   input  logic [2:0]                          num_zero,
   input  logic [2:0]                          num_big,
   input  logic [2:0]                          num_small,
   input  logic [3*WORD_BITS-1:0]              num_word,
   input  logic                                w_neg,
   input  logic [3*(WORD_BITS+1)-1:0]          quo,
   input  logic [2:0]                          ovf,
   output avt_pkg::rsp_payload_type            rsp_ff
);
   import avt_pkg::*;

   localparam logic [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS:0]   LIM  = {2'b01, {(WORD_BITS-1){1'b0}}};

   logic [WORD_BITS-1:0] res [3];
   logic [2:0]           sat;
   rsp_payload_type      rsp_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [WORD_BITS:0] mag;
         logic               neg;
         mag    = quo[i*(WORD_BITS+1) +: WORD_BITS+1];
         neg    = num_neg[i] ^ w_neg;
         sat[i] = 1'b0;
         if (ctl.w_one) begin
            if (num_big[i]) begin
               res[i] = MAXW; sat[i] = 1'b1;
            end else if (num_small[i]) begin
               res[i] = MINW; sat[i] = 1'b1;
            end else begin
               res[i] = num_word[i*WORD_BITS +: WORD_BITS];
            end
         end else if (ctl.w_zero) begin
            if (num_zero[i]) begin
               res[i] = '0;
            end else begin
               res[i] = num_neg[i] ? MINW : MAXW; sat[i] = 1'b1;
            end
         end else if (neg) begin
            if (ovf[i] || mag > LIM) begin
               res[i] = MINW; sat[i] = 1'b1;
            end else begin
               res[i] = WORD_BITS'(-mag);
            end
         end else begin
            if (ovf[i] || mag > (WORD_BITS+1)'(MAXW)) begin
               res[i] = MAXW; sat[i] = 1'b1;
            end else begin
               res[i] = mag[WORD_BITS-1:0];
            end
         end
      end
      rsp_in.x_out     = COORD_BITS'($signed(res[0]));
      rsp_in.y_out     = COORD_BITS'($signed(res[1]));
      rsp_in.z_out     = COORD_BITS'($signed(res[2]));
      rsp_in.rescaled  = !ctl.w_one;
      rsp_in.div_zero  = ctl.w_zero;
      rsp_in.saturated = |sat;
      rsp_in.last_out  = ctl.last;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/avt_checker.sv =====
module avt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input avt_pkg::rsp_payload_type rsp_data,
   input logic                     req_ready
);
   import avt_pkg::*;

   // Response holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Zero w always means a rescale
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |-> rsp_data.rescaled)
      else $error("div_zero without rescaled");

   // Input is taken whenever the output slot is free
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // No response right after reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind affine_vertex_transform avt_checker u_avt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data),
   .req_ready (req.ready)
);

// ===== dv/affine_vertex_transform_test_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come from the rtl folder; the testbench adds none.

// ===== dv/affine_vertex_transform_test.sv =====
`timescale 1ns / 1ps
module affine_vertex_transform_test;
   import avt_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 38;
   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;

   avt_req_if req ();
   avt_rsp_if rsp ();
   avt_csr_if csr ();

   affine_vertex_transform uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // matrix copy used for prediction
   reg_word_type matrix_regs [NUM_REGS];

   req_payload_type pending_vertices [$];
   rsp_payload_type expected_vertices [$];
   int error_count = 0;
   bit idle_off = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int take_gap = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic longint coef_of(int row, int col);
      reg_word_type r;
      r = matrix_regs[row * 2 + col / 2];
      return (col % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
   endfunction

   // floored product sum plus translation
   function automatic longint row_total(int row, longint v [3]);
      longint acc;
      acc = coef_of(row, 3);
      for (int j = 0; j < 3; j++) acc += (coef_of(row, j) * v[j]) >>> FRAC;
      return acc;
   endfunction

   function automatic longint divide_fix(longint n, longint w, ref bit sat);
      logic [63:0] an, aw, q, r, mag, lim;
      bit neg;
      an = (n < 0) ? -n : n;
      aw = (w < 0) ? -w : w;
      q = an / aw;
      r = an % aw;
      lim = 64'd2147483648;
      neg = (n < 0) != (w < 0);
      if (q > (lim >> FRAC)) mag = lim + 1;
      else begin
         mag = (q << FRAC) + (r << FRAC) / aw;
         if (mag > lim + 1) mag = lim + 1;
      end
      if (neg) begin
         if (mag > lim) begin
            sat = 1'b1;
            return MINV;
         end
         return -longint'(mag);
      end
      if (mag > lim - 1) begin
         sat = 1'b1;
         return MAXV;
      end
      return longint'(mag);
   endfunction

   function automatic rsp_payload_type transform_vertex(req_payload_type a);
      longint v [3];
      longint n [3];
      longint w, res [3];
      bit sat, dz, resc;
      rsp_payload_type o;
      sat = 0; dz = 0; resc = 0;
      v[0] = a.x_in; v[1] = a.y_in; v[2] = a.z_in;
      for (int i = 0; i < 3; i++) n[i] = row_total(i, v);
      w = row_total(3, v);
      for (int i = 0; i < 3; i++) begin
         if (w == 65536) begin
            res[i] = n[i];
            if (n[i] > MAXV) begin res[i] = MAXV; sat = 1; end
            if (n[i] < MINV) begin res[i] = MINV; sat = 1; end
         end else if (w == 0) begin
            resc = 1; dz = 1;
            res[i] = (n[i] > 0) ? MAXV : (n[i] < 0) ? MINV : 0;
            if (n[i] != 0) sat = 1;
         end else begin
            resc = 1;
            res[i] = divide_fix(n[i], w, sat);
         end
      end
      o.x_out = res[0][31:0]; o.y_out = res[1][31:0]; o.z_out = res[2][31:0];
      o.rescaled = resc; o.div_zero = dz; o.saturated = sat; o.last_out = a.last_in;
      return o;
   endfunction

   // request driver; a request not yet taken is held as it is
   always @(negedge clock) begin
      if (reset) req.valid <= 1'b0;
      else if (req.valid && !req_taken) begin
      end else if (!idle_off && send_gap == 0 && $urandom_range(0, 19) == 0) begin
         send_gap = $urandom_range(0, 14);
         req.valid <= 1'b0;
      end else if (send_gap > 0) begin
         send_gap--;
         req.valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
         req.data <= pending_vertices[0];
         req.valid <= 1'b1;
      end else req.valid <= 1'b0;
   end

   // accepted requests get a prediction
   always @(posedge clock) begin
      req_taken = !reset && req.valid && req.ready;
      if (req_taken) begin
         expected_vertices.push_back(transform_vertex(req.data));
         void'(pending_vertices.pop_front());
      end
   end

   // response ready with bursts of stall
   always @(negedge clock) begin
      if (reset || idle_off) rsp.ready <= 1'b1;
      else if (take_gap > 0) begin
         take_gap--;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
         take_gap = $urandom_range(0, 14);
         rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
   end

   // response monitor
   always @(posedge clock) begin
      rsp_payload_type e, g;
      if (!reset && rsp.valid && rsp.ready) begin
         g = rsp.data;
         if (expected_vertices.size() == 0) report("unexpected response", 0, 0);
         else begin
            e = expected_vertices.pop_front();
            if (g.x_out !== e.x_out) report("x_out", g.x_out, e.x_out);
            if (g.y_out !== e.y_out) report("y_out", g.y_out, e.y_out);
            if (g.z_out !== e.z_out) report("z_out", g.z_out, e.z_out);
            if (g.rescaled !== e.rescaled) report("rescaled", g.rescaled, e.rescaled);
            if (g.div_zero !== e.div_zero) report("div_zero", g.div_zero, e.div_zero);
            if (g.saturated !== e.saturated) report("saturated", g.saturated, e.saturated);
            if (g.last_out !== e.last_out) report("last_out", g.last_out, e.last_out);
         end
      end
   end

   task automatic wait_drained();
      while (pending_vertices.size() > 0 || expected_vertices.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input reg_word_type value);
      @(negedge clock);
      csr.index <= IDX_BITS'(index);
      csr.wdata <= value;
      csr.valid <= 1'b1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      matrix_regs[index] = value;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic reg_word_type pack_pair(logic [31:0] lo, logic [31:0] hi);
      return {hi, lo};
   endfunction

   task automatic queue_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      req_payload_type p;
      p.x_in = x; p.y_in = y; p.z_in = z; p.last_in = last;
      pending_vertices.push_back(p);
   endtask

   // random matrix; row 3 chosen among identity, zero w, and general
   task automatic load_matrix(int style);
      for (int r = 0; r < 4; r++) begin
         logic [31:0] c [4];
         for (int k = 0; k < 4; k++)
            c[k] = (style == 2) ? $urandom : rand_coord($urandom_range(0, 9) == 0 ? 1 : 0);
         if (r == 3 && style == 0) begin c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 32'h10000; end
         if (r == 3 && style == 1) begin c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 0; end
         write_reg(3'(r * 2), pack_pair(c[0], c[1]));
         write_reg(3'(r * 2 + 1), pack_pair(c[2], c[3]));
      end
   endtask

   initial begin
      logic [31:0] extremes [5] = '{32'h0, 32'h10000, 32'hffff0000, 32'h7fffffff, 32'h80000000};
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.wdata = '0;
      matrix_regs = '{64'h10000, 64'h0, 64'h10000_00000000, 64'h0,
                      64'h0, 64'h10000, 64'h0, 64'h10000_00000000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity at reset: extremes pass through
      for (int i = 0; i < 5; i++)
         queue_vertex(extremes[i], extremes[(i + 1) % 5], extremes[(i + 2) % 5], i[0]);
      wait_drained();

      // all-ones coefficients, then max and min coefficients in alternate columns
      for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), '1);
      for (int i = 0; i < 5; i++) queue_vertex(extremes[i], extremes[4 - i], 32'h30000, 1'b0);
      wait_drained();
      for (int r = 0; r < NUM_REGS; r++) write_reg(3'(r), {32'h7fffffff, 32'h80000000});
      for (int i = 0; i < 5; i++) queue_vertex(extremes[i], 32'h1, extremes[i], 1'b1);
      wait_drained();

      // zero w with positive, negative and zero numerators
      load_matrix(1);
      write_reg(REG_ROW0_COLS01, pack_pair(32'h10000, 32'h0));
      write_reg(REG_ROW1_COLS01, pack_pair(32'hffff0000, 32'h0));
      write_reg(REG_ROW2_COLS01, '0);
      write_reg(REG_ROW2_COLS23, '0);
      queue_vertex(32'h50000, 32'h0, 32'h0, 1'b0);
      queue_vertex(32'hfffb0000, 32'h0, 32'h0, 1'b1);
      queue_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      wait_drained();

      // random phases across matrix styles
      for (int ph = 0; ph < 13; ph++) begin
         load_matrix(ph % 4 == 3 ? 2 : ph % 3);
         if (ph == 12) idle_off = 1'b1;
         for (int i = 0; i < 150; i++)
            queue_vertex(rand_coord($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0),
                         rand_coord($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0),
                         rand_coord($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0),
                         1'($urandom));
         wait_drained();
      end

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== affine_vertex_transform.f =====
rtl/avt_pkg.sv
rtl/avt_if.sv
rtl/avt_lane.sv
rtl/avt_divider.sv
rtl/avt_merge.sv
rtl/affine_vertex_transform.sv
rtl/avt_checker.sv
dv/affine_vertex_transform_test_if.sv
dv/affine_vertex_transform_test.sv
